[hdl/ptq_pkg.sv]
// Shared types and constants of the priority task queue.
// Depends on nothing; every other file of the block but ptq_fifo refers to it.
package ptq_pkg;

   localparam int NUM_LEVELS_DEF = 4;
   localparam int RING_SIZE_DEF  = 16;
   localparam int CMD_DEPTH      = 2;
   localparam int RSP_DEPTH      = 2;

   localparam int DATA_W    = 32;
   localparam int PRIO_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int PENDING_W = 6;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_WRITE,
      CMD_READ
   } cmd_op_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [DATA_W-1:0]    handle;
      logic [DATA_W-1:0]    argument;
      logic [PRIO_W-1:0]    prio;
      logic [PENDING_W-1:0] pending;
      logic [PENDING_W-1:0] peak;
   } rsp_type;

endpackage

[hdl/priority_task_queue_core.sv]
// Top level of the strict-priority multi-ring task queue.
// Depends on ptq_pkg, ptq_fifo, ptq_front and ptq_back.
//
//   channel   direction  handshake       accept condition     payload
//   request   in         push / full     push && !full        req_kind, req_priority_req,
//                                                             req_task_handle, req_task_argument
//   response  out        pop / empty     pop && !empty        rsp_status, rsp_out_handle,
//                                                             rsp_out_argument, rsp_out_priority,
//                                                             rsp_pending_total, rsp_peak_pending
//
// Every request transaction yields exactly one response transaction, in order.
// The front end resolves a transaction in its accept cycle; the command queue, the
// back end's store stage and the response queue then each register it on its way to
// the response side. One transaction per cycle is sustained while pop keeps up; the
// single store port (one write or one read per cycle) sets that figure.
// Reset is synchronous, active high: all rings empty, counts zero, queues drained.
// full rises when the two-entry command queue fills, i.e. when responses back up.
module priority_task_queue_core #(
   parameter int NUM_LEVELS = ptq_pkg::NUM_LEVELS_DEF,
   parameter int RING_SIZE  = ptq_pkg::RING_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic                            req_kind,
   input  logic [ptq_pkg::PRIO_W-1:0]      req_priority_req,
   input  logic [ptq_pkg::DATA_W-1:0]      req_task_handle,
   input  logic [ptq_pkg::DATA_W-1:0]      req_task_argument,
   output logic                            empty,
   input  logic                            pop,
   output logic [ptq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ptq_pkg::DATA_W-1:0]      rsp_out_handle,
   output logic [ptq_pkg::DATA_W-1:0]      rsp_out_argument,
   output logic [ptq_pkg::PRIO_W-1:0]      rsp_out_priority,
   output logic [ptq_pkg::PENDING_W-1:0]   rsp_pending_total,
   output logic [ptq_pkg::PENDING_W-1:0]   rsp_peak_pending
);

   localparam int STORE_DEPTH = NUM_LEVELS * RING_SIZE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // Command from front to back: store access plus the finished response fields.
   typedef struct packed {
      ptq_pkg::cmd_op_type        op;
      logic [ADDR_W-1:0]          addr;
      logic [ptq_pkg::DATA_W-1:0] wr_handle;
      logic [ptq_pkg::DATA_W-1:0] wr_argument;
      ptq_pkg::rsp_type           rsp;
   } cmd_type;

   cmd_type          front_cmd, queue_cmd;
   logic             cmd_full, cmd_empty, cmd_pop;
   logic             accept;
   logic             rsp_full, rsp_push;
   ptq_pkg::rsp_type back_rsp, head_rsp;

   // Take a request whenever the command queue has room.
   assign full   = cmd_full;
   assign accept = push && !cmd_full;

   ptq_front #(
      .NUM_LEVELS (NUM_LEVELS),
      .RING_SIZE  (RING_SIZE),
      .cmd_type   (cmd_type)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_kind          (req_kind),
      .req_priority_req  (req_priority_req),
      .req_task_handle   (req_task_handle),
      .req_task_argument (req_task_argument),
      .cmd_data          (front_cmd)
   );

   // Decouple classification from store access.
   ptq_fifo #(
      .DEPTH     (ptq_pkg::CMD_DEPTH),
      .item_type (cmd_type)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (queue_cmd),
      .empty     (cmd_empty)
   );

   ptq_back #(
      .STORE_DEPTH (STORE_DEPTH),
      .cmd_type    (cmd_type)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (queue_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (back_rsp)
   );

   // Hold finished responses until the consumer pops them.
   ptq_fifo #(
      .DEPTH     (ptq_pkg::RSP_DEPTH),
      .item_type (ptq_pkg::rsp_type)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (head_rsp),
      .empty     (empty)
   );

   assign rsp_status        = head_rsp.status;
   assign rsp_out_handle    = head_rsp.handle;
   assign rsp_out_argument  = head_rsp.argument;
   assign rsp_out_priority  = head_rsp.prio;
   assign rsp_pending_total = head_rsp.pending;
   assign rsp_peak_pending  = head_rsp.peak;

endmodule

[hdl/ptq_fifo.sv]
// Small synchronous FIFO for any packed item type.
// Depends on nothing; used for the command queue and the result queue.
module ptq_fifo #(
   parameter int  DEPTH     = 2,
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           entry_ff [DEPTH];
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_idx_ff];

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_idx_in = (wr_idx_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
      end
      if (do_pop) begin
         rd_idx_in = (rd_idx_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_idx_ff] <= push_data;
      end
   end

endmodule

[hdl/ptq_front.sv]
// Front end: accepts transactions, keeps ring pointers and counts, issues commands.
// Depends on ptq_pkg; its commands go to the command queue and on to ptq_back.
module ptq_front #(
   parameter int  NUM_LEVELS = ptq_pkg::NUM_LEVELS_DEF,
   parameter int  RING_SIZE  = ptq_pkg::RING_SIZE_DEF,
   parameter type cmd_type   = logic
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         req_kind,
   input  logic [ptq_pkg::PRIO_W-1:0]   req_priority_req,
   input  logic [ptq_pkg::DATA_W-1:0]   req_task_handle,
   input  logic [ptq_pkg::DATA_W-1:0]   req_task_argument,
   output cmd_type                      cmd_data
);

   localparam int PTR_W       = $clog2(RING_SIZE);
   localparam int LVL_W       = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int MAX_PENDING = NUM_LEVELS * (RING_SIZE - 1);
   localparam int RAW_CNT_W   = $clog2(MAX_PENDING + 1);
   localparam int CNT_W       = (RAW_CNT_W > ptq_pkg::PENDING_W) ? RAW_CNT_W
                                                                 : ptq_pkg::PENDING_W;
   localparam int ADDR_W      = $bits(cmd_data.addr);

   logic [PTR_W-1:0]      wr_ptr_ff [NUM_LEVELS];
   logic [PTR_W-1:0]      rd_ptr_ff [NUM_LEVELS];
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      peak_ff, peak_in;
   logic [NUM_LEVELS-1:0] nonempty;
   logic                  any_pending;
   logic [LVL_W-1:0]      pop_lvl, lvl_sel;
   logic [PTR_W-1:0]      wp, rp, wp_next, rp_next, slot_ptr;
   logic                  is_push, prio_ok, push_ok, pop_ok;

   for (genvar i = 0; i < NUM_LEVELS; i++) begin : g_level
      assign nonempty[i] = (rd_ptr_ff[i] != wr_ptr_ff[i]);
   end

   assign any_pending = |nonempty;

   // lowest-numbered non-empty ring wins
   always_comb begin
      pop_lvl = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (nonempty[i]) begin
            pop_lvl = LVL_W'(i);
         end
      end
   end

   assign is_push  = (req_kind == ptq_pkg::KIND_PUSH);
   assign prio_ok  = (int'(req_priority_req) < NUM_LEVELS);
   assign lvl_sel  = is_push ? LVL_W'(req_priority_req) : pop_lvl;
   assign wp       = wr_ptr_ff[lvl_sel];
   assign rp       = rd_ptr_ff[lvl_sel];
   assign wp_next  = (wp == PTR_W'(RING_SIZE - 1)) ? '0 : wp + 1'b1;
   assign rp_next  = (rp == PTR_W'(RING_SIZE - 1)) ? '0 : rp + 1'b1;
   assign push_ok  = is_push && prio_ok && (wp_next != rp);
   assign pop_ok   = !is_push && any_pending;
   assign slot_ptr = is_push ? wp : rp;

   always_comb begin
      count_in = count_ff;
      if (push_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok) begin
         count_in = count_ff - 1'b1;
      end
      peak_in = (count_in > peak_ff) ? count_in : peak_ff;
   end

   always_comb begin
      cmd_data              = '0;
      cmd_data.addr         = ADDR_W'(int'(lvl_sel) * RING_SIZE + int'(slot_ptr));
      cmd_data.wr_handle    = req_task_handle;
      cmd_data.wr_argument  = req_task_argument;
      cmd_data.rsp.pending  = count_in[ptq_pkg::PENDING_W-1:0];
      cmd_data.rsp.peak     = peak_in[ptq_pkg::PENDING_W-1:0];
      if (is_push) begin
         cmd_data.op         = push_ok ? ptq_pkg::CMD_WRITE : ptq_pkg::CMD_NONE;
         cmd_data.rsp.status = push_ok ? ptq_pkg::STATUS_OK : ptq_pkg::STATUS_FULL;
      end else begin
         cmd_data.op         = pop_ok ? ptq_pkg::CMD_READ : ptq_pkg::CMD_NONE;
         cmd_data.rsp.status = pop_ok ? ptq_pkg::STATUS_OK : ptq_pkg::STATUS_EMPTY;
         cmd_data.rsp.prio   = pop_ok ? ptq_pkg::PRIO_W'(pop_lvl) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            wr_ptr_ff[i] <= '0;
            rd_ptr_ff[i] <= '0;
         end
         count_ff <= '0;
         peak_ff  <= '0;
      end else if (accept) begin
         if (push_ok) begin
            wr_ptr_ff[lvl_sel] <= wp_next;
         end
         if (pop_ok) begin
            rd_ptr_ff[lvl_sel] <= rp_next;
         end
         count_ff <= count_in;
         peak_ff  <= peak_in;
      end
   end

`ifndef SYNTHESIS
   a_peak_covers_count: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= count_ff)
      else $error("peak below pending count");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PENDING))
      else $error("pending count beyond ring capacity");

   a_pop_drops_count: assert property (@(posedge clock) disable iff (reset)
      accept && !is_push && any_pending |=> count_ff == $past(count_ff) - 1'b1)
      else $error("successful pop did not lower pending count");

   a_empty_means_zero: assert property (@(posedge clock) disable iff (reset)
      !any_pending |-> count_ff == '0)
      else $error("all rings empty but count nonzero");
`endif

endmodule

[hdl/ptq_back.sv]
// Back end: executes ring store writes and reads and forms result transactions.
// Depends on ptq_pkg; takes commands from the command queue, feeds the result queue.
module ptq_back #(
   parameter int  STORE_DEPTH = ptq_pkg::NUM_LEVELS_DEF * ptq_pkg::RING_SIZE_DEF,
   parameter type cmd_type    = logic
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   input  cmd_type          cmd_data,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output ptq_pkg::rsp_type rsp_data
);

   logic [ptq_pkg::DATA_W-1:0] handle_mem   [STORE_DEPTH];
   logic [ptq_pkg::DATA_W-1:0] argument_mem [STORE_DEPTH];

   logic                       stage_valid_ff, stage_valid_in;
   logic                       stage_read_ff;
   ptq_pkg::rsp_type           stage_rsp_ff;
   logic [ptq_pkg::DATA_W-1:0] rd_handle_ff, rd_argument_ff;
   logic                       take;

   assign take     = !cmd_empty && (!stage_valid_ff || !rsp_full);
   assign cmd_pop  = take;
   assign rsp_push = stage_valid_ff && !rsp_full;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (take) begin
         stage_valid_in = 1'b1;
      end else if (!rsp_full) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_data = stage_rsp_ff;
      if (stage_read_ff) begin
         rsp_data.handle   = rd_handle_ff;
         rsp_data.argument = rd_argument_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_rsp_ff  <= cmd_data.rsp;
         stage_read_ff <= (cmd_data.op == ptq_pkg::CMD_READ);
         unique case (cmd_data.op)
            ptq_pkg::CMD_WRITE: begin
               handle_mem[cmd_data.addr]   <= cmd_data.wr_handle;
               argument_mem[cmd_data.addr] <= cmd_data.wr_argument;
            end
            ptq_pkg::CMD_READ: begin
               rd_handle_ff   <= handle_mem[cmd_data.addr];
               rd_argument_ff <= argument_mem[cmd_data.addr];
            end
            default: begin
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && rsp_full |=> stage_valid_ff && $stable(stage_rsp_ff))
      else $error("blocked result stage lost its transaction");

   a_forward_when_free: assert property (@(posedge clock) disable iff (reset)
      !cmd_empty && !stage_valid_ff |-> cmd_pop)
      else $error("back end stalled with a free stage");
`endif

endmodule

[tb/ptq_checker.sv]
// Response checker for the priority task queue: watches both channels, predicts
// every response from the accepted requests and compares it field by field.
// Depends on ptq_pkg.
module ptq_checker #(
   parameter int NUM_LEVELS = ptq_pkg::NUM_LEVELS_DEF,
   parameter int RING_SIZE  = ptq_pkg::RING_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic                            full,
   input  logic                            req_kind,
   input  logic [ptq_pkg::PRIO_W-1:0]      req_priority_req,
   input  logic [ptq_pkg::DATA_W-1:0]      req_task_handle,
   input  logic [ptq_pkg::DATA_W-1:0]      req_task_argument,
   input  logic                            empty,
   input  logic                            pop,
   input  logic [ptq_pkg::STATUS_W-1:0]    rsp_status,
   input  logic [ptq_pkg::DATA_W-1:0]      rsp_out_handle,
   input  logic [ptq_pkg::DATA_W-1:0]      rsp_out_argument,
   input  logic [ptq_pkg::PRIO_W-1:0]      rsp_out_priority,
   input  logic [ptq_pkg::PENDING_W-1:0]   rsp_pending_total,
   input  logic [ptq_pkg::PENDING_W-1:0]   rsp_peak_pending,
   input  logic                            end_of_test,
   output int                              mismatch_count,
   output int                              outstanding,
   output bit                              drain_checked
);
   import ptq_pkg::*;

   logic [DATA_W-1:0] handle_ring   [NUM_LEVELS][RING_SIZE];
   logic [DATA_W-1:0] argument_ring [NUM_LEVELS][RING_SIZE];
   int                wr_slot [NUM_LEVELS];
   int                rd_slot [NUM_LEVELS];
   int                task_count;
   int                task_peak;
   int                result_index;
   rsp_type           outcome_fifo [$];
   rsp_type           predicted;
   rsp_type           want;

   function automatic int ring_advance(input int slot);
      return (slot + 1 >= RING_SIZE) ? 0 : slot + 1;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 50) $display("ptq_checker: %s", msg);
      mismatch_count++;
   endtask

   // Apply one request to the shadow rings and work out its response.
   task automatic predict_outcome(input logic kind, input logic [PRIO_W-1:0] level,
                                  input logic [DATA_W-1:0] handle,
                                  input logic [DATA_W-1:0] argument,
                                  output rsp_type outcome);
      int nxt;
      int lvl;
      bit found;
      outcome = '0;
      found   = 1'b0;
      if (kind == KIND_PUSH) begin
         if (int'(level) >= NUM_LEVELS) begin
            outcome.status = STATUS_FULL;
         end else begin
            nxt = ring_advance(wr_slot[level]);
            if (nxt == rd_slot[level]) begin
               outcome.status = STATUS_FULL;
            end else begin
               handle_ring[level][wr_slot[level]]   = handle;
               argument_ring[level][wr_slot[level]] = argument;
               wr_slot[level] = nxt;
               task_count++;
               if (task_count > task_peak) task_peak = task_count;
            end
         end
      end else begin
         for (lvl = 0; lvl < NUM_LEVELS && !found; lvl++) begin
            if (rd_slot[lvl] != wr_slot[lvl]) begin
               outcome.handle   = handle_ring[lvl][rd_slot[lvl]];
               outcome.argument = argument_ring[lvl][rd_slot[lvl]];
               outcome.prio     = PRIO_W'(lvl);
               rd_slot[lvl]     = ring_advance(rd_slot[lvl]);
               if (task_count > 0) task_count--;
               found = 1'b1;
            end
         end
         if (!found) outcome.status = STATUS_EMPTY;
      end
      outcome.pending = PENDING_W'(task_count);
      outcome.peak    = PENDING_W'(task_peak);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (wr_slot[i]) begin
            wr_slot[i] = 0;
            rd_slot[i] = 0;
         end
         task_count   = 0;
         task_peak    = 0;
         result_index = 0;
         outcome_fifo.delete();
      end else begin
         // Record the request first: a response can never precede its request.
         if (push && !full) begin
            predict_outcome(req_kind, req_priority_req, req_task_handle, req_task_argument,
                            predicted);
            outcome_fifo.push_back(predicted);
         end
         if (pop && !empty) begin
            if (outcome_fifo.size() == 0) begin
               report_mismatch($sformatf("response %0d with no transaction waiting",
                                         result_index));
            end else begin
               want = outcome_fifo.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("response %0d status got %0d want %0d",
                                            result_index, rsp_status, want.status));
               if (rsp_out_handle !== want.handle)
                  report_mismatch($sformatf("response %0d handle got %h want %h",
                                            result_index, rsp_out_handle, want.handle));
               if (rsp_out_argument !== want.argument)
                  report_mismatch($sformatf("response %0d argument got %h want %h",
                                            result_index, rsp_out_argument, want.argument));
               if (rsp_out_priority !== want.prio)
                  report_mismatch($sformatf("response %0d priority got %0d want %0d",
                                            result_index, rsp_out_priority, want.prio));
               if (rsp_pending_total !== want.pending)
                  report_mismatch($sformatf("response %0d pending got %0d want %0d",
                                            result_index, rsp_pending_total, want.pending));
               if (rsp_peak_pending !== want.peak)
                  report_mismatch($sformatf("response %0d peak got %0d want %0d",
                                            result_index, rsp_peak_pending, want.peak));
            end
            result_index++;
         end
         if (end_of_test && !drain_checked) begin
            if (outcome_fifo.size() != 0)
               report_mismatch($sformatf("%0d responses never arrived", outcome_fifo.size()));
            drain_checked <= 1'b1;
         end
      end
      outstanding <= outcome_fifo.size();
   end

endmodule

[tb/tb_priority_task_queue_core.sv]
// Testbench top for priority_task_queue_core: drives request and response traffic
// under several idle patterns and gives the verdict.
// Depends on ptq_pkg, priority_task_queue_core and ptq_checker.
module tb_priority_task_queue_core;
   import ptq_pkg::*;

   localparam int      PHASE_ITEMS  = 425;   // random transactions per idle phase
   localparam int      GROUP_ITEMS  = 50;    // transactions sharing one traffic mix
   localparam int      HOLD_CYCLES  = 60;    // long receiver hold-off
   localparam int      DRAIN_LIMIT  = 2000;  // cycles allowed for the last responses
   localparam int      SETTLE_CYCLES = 8;    // wait after the drain for stray responses
   localparam longint  RUN_LIMIT    = 4_000_000;

   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   logic                  req_kind;
   logic [PRIO_W-1:0]     req_priority_req;
   logic [DATA_W-1:0]     req_task_handle;
   logic [DATA_W-1:0]     req_task_argument;
   logic                  empty;
   logic                  pop;
   logic [STATUS_W-1:0]   rsp_status;
   logic [DATA_W-1:0]     rsp_out_handle;
   logic [DATA_W-1:0]     rsp_out_argument;
   logic [PRIO_W-1:0]     rsp_out_priority;
   logic [PENDING_W-1:0]  rsp_pending_total;
   logic [PENDING_W-1:0]  rsp_peak_pending;

   logic                  end_of_test;
   int                    mismatch_count;
   int                    outstanding;
   bit                    drain_checked;

   // Idle controls shared by the sender and receiver processes.
   int                    send_idle_pct;
   int                    recv_stall_pct;
   bit                    hold_off_req;

   priority_task_queue_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_kind          (req_kind),
      .req_priority_req  (req_priority_req),
      .req_task_handle   (req_task_handle),
      .req_task_argument (req_task_argument),
      .empty             (empty),
      .pop               (pop),
      .rsp_status        (rsp_status),
      .rsp_out_handle    (rsp_out_handle),
      .rsp_out_argument  (rsp_out_argument),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_pending_total (rsp_pending_total),
      .rsp_peak_pending  (rsp_peak_pending)
   );

   ptq_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_kind          (req_kind),
      .req_priority_req  (req_priority_req),
      .req_task_handle   (req_task_handle),
      .req_task_argument (req_task_argument),
      .empty             (empty),
      .pop               (pop),
      .rsp_status        (rsp_status),
      .rsp_out_handle    (rsp_out_handle),
      .rsp_out_argument  (rsp_out_argument),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_pending_total (rsp_pending_total),
      .rsp_peak_pending  (rsp_peak_pending),
      .end_of_test       (end_of_test),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding),
      .drain_checked     (drain_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop: far beyond the slowest correct run.
   initial begin
      #(RUN_LIMIT);
      $display("priority_task_queue_core: mismatch");
      $finish;
   end

   // Offer one request and hold it until the block takes it. Insert random idle
   // cycles first, so gaps land in every phase of the block's pipeline.
   task automatic send_item(input logic kind, input logic [PRIO_W-1:0] level,
                            input logic [DATA_W-1:0] handle,
                            input logic [DATA_W-1:0] argument);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push              <= 1'b1;
      req_kind          <= kind;
      req_priority_req  <= level;
      req_task_handle   <= handle;
      req_task_argument <= argument;
      // The sampled full at this edge decides whether the transaction went in.
      @(posedge clock);
      while (full !== 1'b0) @(posedge clock);
   endtask

   // Receiver: pop at random, or hold off for a long stretch on request so that
   // responses back up and full rises on the request side.
   initial begin
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      int            i;
      int            phase;
      int            n;
      int            push_bias;
      int            focus_level;
      int            waited;
      logic          kind;
      logic [PRIO_W-1:0] level;

      reset             <= 1'b1;
      push              <= 1'b0;
      req_kind          <= KIND_PUSH;
      req_priority_req  <= '0;
      req_task_handle   <= '0;
      req_task_argument <= '0;
      end_of_test       <= 1'b0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      hold_off_req      = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      // Pop with nothing pending; ignored fields at their top values.
      send_item(KIND_POP, 2'd3, '1, '1);
      // One task on each lower level, handle and argument at both extremes.
      send_item(KIND_PUSH, 2'd3, '0, '0);
      send_item(KIND_PUSH, 2'd2, '1, '1);
      send_item(KIND_PUSH, 2'd1, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
      // Fill level 0 to its capacity; the sixteenth push hits a full ring.
      for (i = 0; i < 16; i++)
         send_item(KIND_PUSH, 2'd0, 32'h8000_0000 | i, ~i);
      // Pop from level 0 first, strict priority over the older tasks below it.
      for (i = 0; i < 5; i++)
         send_item(KIND_POP, PRIO_W'(i), $urandom, $urandom);

      // Random part: four idle phases, each with changing traffic mixes so that
      // rings fill up, overflow and drain again.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               // Hold off the receiver while requests keep coming.
               hold_off_req   = 1'b1;
            end
            1: begin
               send_idle_pct  = 65;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 65;
            end
            default: begin
               send_idle_pct  = 7;
               recv_stall_pct = 7;
            end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % GROUP_ITEMS == 0) begin
               case ($urandom_range(3))
                  0:       push_bias = 20;
                  1:       push_bias = 50;
                  2:       push_bias = 75;
                  default: push_bias = 95;
               endcase
               // A focus of NUM_LEVELS_DEF means no favored level.
               focus_level = $urandom_range(NUM_LEVELS_DEF);
            end
            kind = ($urandom_range(99) < push_bias) ? KIND_PUSH : KIND_POP;
            if (focus_level < NUM_LEVELS_DEF && $urandom_range(3) != 0)
               level = PRIO_W'(focus_level);
            else
               level = PRIO_W'($urandom_range(3));
            send_item(kind, level, $urandom, $urandom);
         end
      end

      // Drop push and drain the remaining responses.
      push           <= 1'b0;
      recv_stall_pct  = 0;
      @(posedge clock);
      waited = 0;
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      // Catch any stray response after the last expected one.
      repeat (SETTLE_CYCLES) @(posedge clock);
      end_of_test <= 1'b1;
      @(posedge clock);
      while (!drain_checked) @(posedge clock);
      @(posedge clock);

      if (mismatch_count == 0) begin
         $display("priority_task_queue_core: match");
      end else begin
         $display("priority_task_queue_core: mismatch");
      end
      $finish;
   end

endmodule
